@@ rtl/dnch_pkg.sv @@
// Package with the shared types and constants of the day/night climate controller.
`timescale 1ns / 1ps

package dnch_pkg;

  // Widths of the beat payloads and the configuration port.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  // Half width of the hysteresis band around each setpoint.
  localparam int unsigned Band = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_DAY_TEMP_SP   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_NIGHT_TEMP_SP = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DAY_HUMI_SP   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NIGHT_HUMI_SP = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MANUAL_OVR    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DAY_BEGIN     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DAY_END       = 3'd6;

  // Input action kinds carried in tuser.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Sensor commands reported on the output.
  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_TRIG_TEMP = 2'd1,
    CMD_TRIG_HUMI = 2'd2
  } sensor_cmd_t;

  // Four-phase measurement cycle.
  typedef enum logic [3:0] {
    PH_TRIG_TEMP = 4'b0001,
    PH_ACT_TEMP  = 4'b0010,
    PH_TRIG_HUMI = 4'b0100,
    PH_ACT_HUMI  = 4'b1000
  } phase_t;

  // One input beat after unpacking.
  typedef struct packed {
    logic              action;
    logic [5:0]        second_now;
    logic [10:0]       minute_of_day;
    logic signed [7:0] temp_sample;
    logic [6:0]        humi_sample;
    logic              light_set;
    logic              heat_set;
    logic              humi_set;
  } in_item_t;

endpackage

@@ rtl/day_night_climate_hysteresis.sv @@
// Top level of the day/night climate controller with hysteresis control.
`timescale 1ns / 1ps
// An input beat passes through the input register and then the result register before its result is offered.
// Throughput: one item per cycle; an input register and a result register each
// hold one beat, so input stalls only when both are full and the output is stalled.
// Reset (rst, synchronous, active high) empties both stages, returns the phase to
// temperature trigger, clears last second and all actuators, and loads register defaults.

module day_night_climate_hysteresis (
  input  logic                           clk,
  input  logic                           rst,
  // Input beat: second_now[5:0], minute_of_day[16:6], temp_sample[24:17],
  // humi_sample[31:25], light_set[32], heat_set[33], humi_set[34], zeros[39:35]
  input  logic [dnch_pkg::InDataW-1:0]   s_tdata,
  // Input kind: action[0]
  input  logic [dnch_pkg::InUserW-1:0]   s_tuser,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // Result beat: sensor_command[1:0], light_on[2], heat_on[3], humidifier_on[4],
  // in_day_window[5], zeros[7:6]
  output logic [dnch_pkg::OutDataW-1:0]  m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // Configuration write port
  input  logic                           cfg_wr_en,
  input  logic [dnch_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dnch_pkg::CfgDataW-1:0]  cfg_data
);

  // Configuration registers.
  logic signed [7:0] day_temp_sp;
  logic signed [7:0] night_temp_sp;
  logic [6:0]        day_humi_sp;
  logic [6:0]        night_humi_sp;
  logic              manual_ovr;
  logic [10:0]       day_begin;
  logic [10:0]       day_end;

  // Controller state.
  dnch_pkg::phase_t phase, phase_next;
  logic [5:0]       last_second, last_second_next;
  logic             light_state, light_state_next;
  logic             heat_state, heat_state_next;
  logic             humid_state, humid_state_next;

  // Pipeline registers.
  logic                in_valid;
  dnch_pkg::in_item_t  in_item;
  logic                advance;

  dnch_pkg::sensor_cmd_t cmd;
  logic                  is_day;
  logic signed [7:0]     temp_sp;
  logic [6:0]            humi_sp;
  logic signed [9:0]     temp_ext;
  logic signed [9:0]     temp_sp_ext;
  logic [7:0]            humi_ext;
  logic [7:0]            humi_sp_ext;
  logic                  temp_low, temp_high, humi_low, humi_high;

  // Register writes from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      day_temp_sp   <= 8'sd15;
      night_temp_sp <= 8'sd15;
      day_humi_sp   <= 7'd10;
      night_humi_sp <= 7'd10;
      manual_ovr    <= 1'b0;
      day_begin     <= '0;
      day_end       <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dnch_pkg::REG_DAY_TEMP_SP:   day_temp_sp   <= cfg_data[7:0];
        dnch_pkg::REG_NIGHT_TEMP_SP: night_temp_sp <= cfg_data[7:0];
        dnch_pkg::REG_DAY_HUMI_SP:   day_humi_sp   <= cfg_data[6:0];
        dnch_pkg::REG_NIGHT_HUMI_SP: night_humi_sp <= cfg_data[6:0];
        dnch_pkg::REG_MANUAL_OVR:    manual_ovr    <= cfg_data[0];
        dnch_pkg::REG_DAY_BEGIN:     day_begin     <= cfg_data[10:0];
        dnch_pkg::REG_DAY_END:       day_end       <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on whenever the result register is free.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action        <= s_tuser[0];
      in_item.second_now    <= s_tdata[5:0];
      in_item.minute_of_day <= s_tdata[16:6];
      in_item.temp_sample   <= s_tdata[24:17];
      in_item.humi_sample   <= s_tdata[31:25];
      in_item.light_set     <= s_tdata[32];
      in_item.heat_set      <= s_tdata[33];
      in_item.humi_set      <= s_tdata[34];
    end
  end

  // Day window test, wrapping past midnight when begin lies after end; equal bounds mean no day.
  always_comb begin
    if (day_begin < day_end) begin
      is_day = (in_item.minute_of_day >= day_begin) && (in_item.minute_of_day < day_end);
    end else if (day_begin > day_end) begin
      is_day = (in_item.minute_of_day >= day_begin) || (in_item.minute_of_day < day_end);
    end else begin
      is_day = 1'b0;
    end
  end

  // Band edges, compared in widened arithmetic to avoid wrap.
  assign temp_sp     = is_day ? day_temp_sp : night_temp_sp;
  assign humi_sp     = is_day ? day_humi_sp : night_humi_sp;
  assign temp_ext    = 10'($signed(in_item.temp_sample));
  assign temp_sp_ext = 10'(temp_sp);
  assign humi_ext    = {1'b0, in_item.humi_sample};
  assign humi_sp_ext = {1'b0, humi_sp};
  assign temp_low    = (temp_ext + $signed(10'(dnch_pkg::Band))) < temp_sp_ext;
  assign temp_high   = temp_ext >= (temp_sp_ext + $signed(10'(dnch_pkg::Band)));
  assign humi_low    = (humi_ext + 8'(dnch_pkg::Band)) <= humi_sp_ext;
  assign humi_high   = humi_ext >= (humi_sp_ext + 8'(dnch_pkg::Band));

  // Phase step and actuator update for the item in the input register.
  always_comb begin
    phase_next       = phase;
    last_second_next = last_second;
    light_state_next = light_state;
    heat_state_next  = heat_state;
    humid_state_next = humid_state;
    cmd              = dnch_pkg::CMD_NONE;
    if (in_item.action == dnch_pkg::ACT_WRITE) begin
      light_state_next = in_item.light_set;
      heat_state_next  = in_item.heat_set;
      humid_state_next = in_item.humi_set;
    end else if (in_item.second_now != last_second) begin
      last_second_next = in_item.second_now;
      unique case (phase)
        dnch_pkg::PH_TRIG_TEMP: begin
          cmd        = dnch_pkg::CMD_TRIG_TEMP;
          phase_next = dnch_pkg::PH_ACT_TEMP;
        end
        dnch_pkg::PH_ACT_TEMP: begin
          if (!manual_ovr) begin
            light_state_next = is_day;
            if (temp_low) begin
              heat_state_next = 1'b1;
            end else if (temp_high) begin
              heat_state_next = 1'b0;
            end
          end
          phase_next = dnch_pkg::PH_TRIG_HUMI;
        end
        dnch_pkg::PH_TRIG_HUMI: begin
          cmd        = dnch_pkg::CMD_TRIG_HUMI;
          phase_next = dnch_pkg::PH_ACT_HUMI;
        end
        dnch_pkg::PH_ACT_HUMI: begin
          if (!manual_ovr) begin
            if (humi_low) begin
              humid_state_next = 1'b1;
            end else if (humi_high) begin
              humid_state_next = 1'b0;
            end
          end
          phase_next = dnch_pkg::PH_TRIG_TEMP;
        end
        default: phase_next = dnch_pkg::PH_TRIG_TEMP;
      endcase
    end
  end

  // State and result register, loaded when the input beat moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dnch_pkg::PH_TRIG_TEMP;
      last_second <= '0;
      light_state <= 1'b0;
      heat_state  <= 1'b0;
      humid_state <= 1'b0;
      m_tvalid    <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        phase       <= phase_next;
        last_second <= last_second_next;
        light_state <= light_state_next;
        heat_state  <= heat_state_next;
        humid_state <= humid_state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tdata <= {2'b00, is_day, humid_state_next, heat_state_next, light_state_next, cmd};
    end
  end

endmodule

@@ rtl/dnch_checker.sv @@
// Port-level checker for the day/night climate controller and its bind.
`timescale 1ns / 1ps

module dnch_checker (
  input logic                           clk,
  input logic                           rst,
  input logic [dnch_pkg::InDataW-1:0]   s_tdata,
  input logic [dnch_pkg::InUserW-1:0]   s_tuser,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [dnch_pkg::OutDataW-1:0]  m_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic                           cfg_wr_en,
  input logic [dnch_pkg::CfgIdxW-1:0]   cfg_index,
  input logic [dnch_pkg::CfgDataW-1:0]  cfg_data
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result beat changed while stalled");

  // The output stage is empty right after a reset cycle.
  a_out_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Input backpressure only arises from a stalled result.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input not ready without an output stall");

  // Sensor command is never the unused code, and padding stays zero.
  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[7:6] == 2'b00))
    else $error("bad sensor command or padding");

endmodule

bind day_night_climate_hysteresis dnch_checker u_dnch_checker (.*);
